@@ design/rgs_pkg.sv @@
// rgs_pkg: shared types, codes and sizes for the region growing segmenter
// used by rgs_ctrl, rgs_dp and region_growing_segmenter; no dependencies
`default_nettype none

package rgs_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned Area       = MaxWidth * MaxHeight;
  localparam int unsigned AddrW      = $clog2(Area);

  localparam logic [8:0] MAX_COLS    = 9'(MaxWidth);
  localparam logic [8:0] MAX_ROWS    = 9'(MaxHeight);
  localparam logic [7:0] LABEL_LIMIT = 8'd255;

  // request actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_SEED  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // frame direction once all four neighbours are tried
  localparam logic [2:0] DIR_DONE = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  pixel_value;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [11:0] criterion;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [16:0] region_size;
    logic [7:0]  label;
    logic        is_border;
  } out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] c;
    logic [2:0] dir;
  } frame_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_Q_STEP,
    OP_READ,
    OP_TEST,
    OP_JOIN,
    OP_NEXT,
    OP_POPLOAD,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic conv_pend;
    logic div_last;
    logic q_last;
    logic go_grow;
    logic go_query;
    logic cand_in;
    logic lab_busy;
    logic first;
    logic next_fin;
    logic next_pop;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ design/rgs_ctrl.sv @@
// rgs_ctrl: sequencing state machine of the region growing segmenter
// depends on rgs_pkg; drives rgs_dp through cmd_t and reads sts_t
`default_nettype none

module rgs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          cfg_valid_i,
  input  rgs_pkg::sts_t      sts_i,
  output logic               in_ready_o,
  output rgs_pkg::cmd_t      cmd_o
);
  import rgs_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_QRY   = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_TEST  = 4'd5;
  localparam logic [3:0] S_JOIN  = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_POPW  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       ready;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    ready     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (sts_i.conv_pend) begin
          cmd_o.op = OP_DIV_INIT;
          state_d  = S_DIV;
        end else begin
          ready = sts_i.out_free && !cfg_valid_i;
          if (ready && in_valid_i) begin
            cmd_o.op = OP_ACCEPT;
            if (sts_i.go_grow) state_d = S_RD;
            else if (sts_i.go_query) state_d = S_QRY;
          end
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_last) state_d = S_IDLE;
      end
      S_QRY: begin
        cmd_o.op = OP_Q_STEP;
        if (sts_i.q_last) state_d = S_FIN;
      end
      S_RD: begin
        cmd_o.op = OP_READ;
        state_d  = sts_i.cand_in ? S_TEST : S_NEXT;
      end
      S_TEST: begin
        cmd_o.op = OP_TEST;
        if (sts_i.lab_busy) state_d = sts_i.first ? S_FIN : S_NEXT;
        else state_d = S_JOIN;
      end
      S_JOIN: begin
        cmd_o.op = OP_JOIN;
        state_d  = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.op = OP_NEXT;
        if (sts_i.next_fin) state_d = S_FIN;
        else if (sts_i.next_pop) state_d = S_POPW;
        else state_d = S_RD;
      end
      S_POPW: begin
        cmd_o.op = OP_POPLOAD;
        state_d  = S_NEXT;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/rgs_dp.sv @@
// rgs_dp: datapath of the region growing segmenter: pixel, label and stack
// memories, running mean test, load position and divider; depends on rgs_pkg
`default_nettype none

module rgs_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  rgs_pkg::cmd_t      cmd_i,
  input  rgs_pkg::in_t       in_data_i,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [8:0]    cfg_data_i,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output rgs_pkg::out_t      out_data_o,
  output rgs_pkg::sts_t      sts_o
);
  import rgs_pkg::*;

  // memories
  logic [7:0]  pix_mem [Area];
  logic [7:0]  lab_mem [Area];
  logic [17:0] stk_mem [Area];

  logic [7:0]  pix_rd, lab_rd;
  logic [17:0] stk_rd;

  // configuration and load position
  logic [8:0]  width_q, height_q, w_eff, h_eff;
  logic [16:0] total_q;
  logic        conv_pend_q;
  logic [15:0] pos_q, lr_q;
  logic [8:0]  lc_q;

  // divider
  logic [15:0] dq_q, dq_n;
  logic [8:0]  rem_q, rem_n;
  logic [3:0]  dcnt_q;
  logic [9:0]  trial;

  logic [15:0] clr_q;
  logic [7:0]  seed_q, lab_q;

  // latched request and walk state
  logic [7:0]  it_row_q, it_col_q;
  logic [11:0] crit_q;
  logic [7:0]  cand_r_q, cand_c_q;
  logic        cand_in_q, first_q;
  frame_t      top_q;
  logic [16:0] sp_q, cnt_q;
  logic [23:0] sum_q;
  logic [24:0] pc_q, diff;
  logic [28:0] cc_q;
  logic        pass;

  // query
  logic [2:0]  qk_q, qidx;
  logic [7:0]  me_q;
  logic        border_q, nb_in, nb_diff;
  logic [15:0] q_addr;

  out_t        res_q, out_q;
  logic        out_valid_q, out_free;
  logic [1:0]  acc_status;

  // load position helpers
  logic        wrap;
  logic [15:0] pos_e, lr_e;
  logic [8:0]  lc_e;
  logic [16:0] npos;

  logic        in_seed, go_grow, go_query;

  // candidate for the next direction
  logic [7:0]  nc_r, nc_c;
  logic        nc_in;

  // memory ports
  logic        lab_we, lab_re, pix_we, pix_re, stk_we, stk_re;
  logic [15:0] lab_wa, lab_ra, pix_wa, cand_addr, stk_wa, stk_ra;
  logic [7:0]  lab_wd;
  logic [17:0] stk_wd;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    if (width_q == 9'd0) w_eff = 9'd1;
    else if (width_q > MAX_COLS) w_eff = MAX_COLS;
    else w_eff = width_q;
    if (height_q == 9'd0) h_eff = 9'd1;
    else if (height_q > MAX_ROWS) h_eff = MAX_ROWS;
    else h_eff = height_q;
  end

  // load address and successor position
  always_comb begin
    wrap  = {1'b0, pos_q} >= total_q;
    pos_e = wrap ? 16'd0 : pos_q;
    lr_e  = wrap ? 16'd0 : lr_q;
    lc_e  = wrap ? 9'd0  : lc_q;
    npos  = {1'b0, pos_e} + 17'd1;
  end

  assign in_seed  = ({1'b0, in_data_i.row} < h_eff) && ({1'b0, in_data_i.col} < w_eff);
  assign go_grow  = (in_data_i.action == ACT_SEED) && (seed_q < LABEL_LIMIT) && in_seed;
  assign go_query = (in_data_i.action == ACT_QUERY) && in_seed;

  // status of a request answered straight away
  always_comb begin
    acc_status = ST_OK;
    if (in_data_i.action == ACT_SEED) begin
      if (seed_q >= LABEL_LIMIT) acc_status = ST_LIMIT;
      else if (!in_seed) acc_status = ST_REJECT;
    end else if (in_data_i.action == ACT_QUERY && !in_seed) begin
      acc_status = ST_REJECT;
    end
  end

  // restoring divide step of the load position by the width
  always_comb begin
    trial = {rem_q, dq_q[15]};
    if (trial >= {1'b0, w_eff}) begin
      rem_n = 9'(trial - {1'b0, w_eff});
      dq_n  = {dq_q[14:0], 1'b1};
    end else begin
      rem_n = trial[8:0];
      dq_n  = {dq_q[14:0], 1'b0};
    end
  end

  // running mean test
  always_comb begin
    diff = ({1'b0, sum_q} > pc_q) ? ({1'b0, sum_q} - pc_q) : (pc_q - {1'b0, sum_q});
    pass = {diff, 4'b0} <= cc_q;
  end

  // next neighbour of the top frame: up, right, down, left
  always_comb begin
    nc_r  = top_q.r;
    nc_c  = top_q.c;
    nc_in = 1'b0;
    case (top_q.dir[1:0])
      2'd0: begin
        nc_r  = top_q.r - 8'd1;
        nc_in = top_q.r != 8'd0;
      end
      2'd1: begin
        nc_c  = top_q.c + 8'd1;
        nc_in = ({1'b0, top_q.c} + 9'd1) < w_eff;
      end
      2'd2: begin
        nc_r  = top_q.r + 8'd1;
        nc_in = ({1'b0, top_q.r} + 9'd1) < h_eff;
      end
      default: begin
        nc_c  = top_q.c - 8'd1;
        nc_in = top_q.c != 8'd0;
      end
    endcase
  end

  // query: read centre then up, right, down, left, one a cycle
  assign qidx = qk_q - 3'd1;
  always_comb begin
    case (qk_q)
      3'd0:    q_addr = {it_row_q, it_col_q};
      3'd1:    q_addr = {it_row_q - 8'd1, it_col_q};
      3'd2:    q_addr = {it_row_q, it_col_q + 8'd1};
      3'd3:    q_addr = {it_row_q + 8'd1, it_col_q};
      default: q_addr = {it_row_q, it_col_q - 8'd1};
    endcase
    case (qidx)
      3'd1:    nb_in = it_row_q != 8'd0;
      3'd2:    nb_in = ({1'b0, it_col_q} + 9'd1) < w_eff;
      3'd3:    nb_in = ({1'b0, it_row_q} + 9'd1) < h_eff;
      3'd4:    nb_in = it_col_q != 8'd0;
      default: nb_in = 1'b0;
    endcase
    nb_diff = nb_in && (lab_rd != me_q);
  end

  assign cand_addr = {cand_r_q, cand_c_q};

  always_comb begin
    lab_we = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_JOIN && pass);
    lab_wa = (cmd_i.op == OP_CLEAR) ? clr_q : cand_addr;
    lab_wd = (cmd_i.op == OP_CLEAR) ? 8'd0 : lab_q;
    lab_re = (cmd_i.op == OP_READ) || (cmd_i.op == OP_Q_STEP);
    lab_ra = (cmd_i.op == OP_READ) ? cand_addr : q_addr;
    pix_we = (cmd_i.op == OP_ACCEPT) && (in_data_i.action == ACT_LOAD);
    pix_wa = {lr_e[7:0], lc_e[7:0]};
    pix_re = cmd_i.op == OP_READ;
    stk_we = (cmd_i.op == OP_JOIN && pass) ||
             (cmd_i.op == OP_NEXT && top_q.dir != DIR_DONE);
    stk_wa = (cmd_i.op == OP_JOIN) ? sp_q[15:0] : 16'(sp_q - 17'd1);
    stk_wd = (cmd_i.op == OP_JOIN) ? {cand_r_q, cand_c_q, 2'd0}
                                   : {top_q.r, top_q.c, top_q.dir[1:0] + 2'd1};
    stk_re = (cmd_i.op == OP_NEXT) && (top_q.dir == DIR_DONE);
    stk_ra = 16'(sp_q - 17'd2);
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[pix_wa] <= in_data_i.pixel_value;
    if (pix_re) pix_rd <= pix_mem[cand_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    if (lab_re) lab_rd <= lab_mem[lab_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd <= stk_mem[stk_ra];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= MAX_COLS;
      height_q    <= MAX_ROWS;
      total_q     <= 17'(Area);
      conv_pend_q <= 1'b0;
      pos_q       <= '0;
      lr_q        <= '0;
      lc_q        <= '0;
      dcnt_q      <= '0;
      clr_q       <= '0;
      seed_q      <= '0;
      sp_q        <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      qk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= {8'd0, w_eff} * {8'd0, h_eff};
      if (cmd_i.op == OP_ACCEPT) out_valid_q <= !(go_grow || go_query);
      else if (cmd_i.op == OP_FINISH) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_WIDTH) width_q <= cfg_data_i;
        if (cfg_index_i == CFG_HEIGHT) height_q <= cfg_data_i;
        conv_pend_q <= 1'b1;
      end else if (cmd_i.op == OP_DIV_INIT) begin
        conv_pend_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLEAR: clr_q <= clr_q + 16'd1;
        OP_DIV_INIT: dcnt_q <= '0;
        OP_DIV_STEP: begin
          dcnt_q <= dcnt_q + 4'd1;
          if (dcnt_q == 4'd15) begin
            lr_q <= dq_n;
            lc_q <= rem_n;
          end
        end
        OP_ACCEPT: begin
          if (in_data_i.action == ACT_LOAD) begin
            if (npos >= total_q) begin
              pos_q <= '0;
              lr_q  <= '0;
              lc_q  <= '0;
            end else begin
              pos_q <= npos[15:0];
              if (lc_e + 9'd1 == w_eff) begin
                lc_q <= '0;
                lr_q <= lr_e + 16'd1;
              end else begin
                lc_q <= lc_e + 9'd1;
                lr_q <= lr_e;
              end
            end
          end
          if (in_data_i.action == ACT_SEED && seed_q < LABEL_LIMIT) seed_q <= seed_q + 8'd1;
          sp_q  <= '0;
          cnt_q <= '0;
          sum_q <= '0;
          qk_q  <= '0;
        end
        OP_Q_STEP: qk_q <= qk_q + 3'd1;
        OP_JOIN: begin
          if (pass) begin
            cnt_q <= cnt_q + 17'd1;
            sum_q <= sum_q + {16'd0, pix_rd};
            sp_q  <= sp_q + 17'd1;
          end
        end
        OP_NEXT: begin
          if (top_q.dir == DIR_DONE && sp_q != 17'd0) sp_q <= sp_q - 17'd1;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        it_row_q  <= in_data_i.row;
        it_col_q  <= in_data_i.col;
        crit_q    <= in_data_i.criterion;
        cand_r_q  <= in_data_i.row;
        cand_c_q  <= in_data_i.col;
        cand_in_q <= 1'b1;
        first_q   <= 1'b1;
        lab_q     <= seed_q + 8'd1;
        border_q  <= 1'b0;
        out_q     <= '{status: acc_status, region_size: '0, label: '0, is_border: 1'b0};
      end
      OP_DIV_INIT: begin
        dq_q  <= pos_q;
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        dq_q  <= dq_n;
        rem_q <= rem_n;
      end
      OP_Q_STEP: begin
        if (qk_q == 3'd1) me_q <= lab_rd;
        if (nb_diff) border_q <= 1'b1;
        res_q <= '{status: ST_OK, region_size: '0, label: me_q,
                   is_border: border_q || nb_diff};
      end
      OP_TEST: begin
        pc_q  <= {17'd0, pix_rd} * {8'd0, cnt_q};
        cc_q  <= {17'd0, crit_q} * {12'd0, cnt_q};
        res_q <= '{status: ST_REJECT, region_size: '0, label: '0, is_border: 1'b0};
      end
      OP_JOIN: begin
        first_q <= 1'b0;
        if (pass) top_q <= '{r: cand_r_q, c: cand_c_q, dir: 3'd0};
      end
      OP_NEXT: begin
        res_q <= '{status: ST_OK, region_size: cnt_q, label: '0, is_border: 1'b0};
        if (top_q.dir != DIR_DONE) begin
          cand_r_q  <= nc_r;
          cand_c_q  <= nc_c;
          cand_in_q <= nc_in;
          top_q.dir <= top_q.dir + 3'd1;
        end
      end
      // a frame below the top has tried at least one neighbour, so a stored
      // direction of zero stands for all four tried
      OP_POPLOAD: top_q <= '{r: stk_rd[17:10], c: stk_rd[9:2],
                             dir: (stk_rd[1:0] == 2'd0) ? DIR_DONE : {1'b0, stk_rd[1:0]}};
      OP_FINISH: out_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.clear_last = clr_q == 16'hFFFF;
    sts_o.conv_pend  = conv_pend_q;
    sts_o.div_last   = dcnt_q == 4'd15;
    sts_o.q_last     = qk_q == 3'd5;
    sts_o.go_grow    = go_grow;
    sts_o.go_query   = go_query;
    sts_o.cand_in    = cand_in_q;
    sts_o.lab_busy   = lab_rd != 8'd0;
    sts_o.first      = first_q;
    sts_o.next_fin   = (sp_q == 17'd0) || (top_q.dir == DIR_DONE && sp_q == 17'd1);
    sts_o.next_pop   = top_q.dir == DIR_DONE;
    sts_o.out_free   = out_free;
  end

`ifndef ASSERT_OFF
  // every stacked frame is a joined pixel
  a_sp_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= cnt_q) else $error("stack deeper than region");

  // a reloaded frame has always tried at least its first neighbour
  a_pop_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POPLOAD) |=> (top_q.dir != 3'd0)) else $error("popped frame untried");

  // a joining pixel never gets the unlabelled code
  a_join_lab: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_JOIN && pass) |-> (lab_q != 8'd0)) else $error("join with zero label");
`endif

endmodule

`default_nettype wire

@@ design/region_growing_segmenter.sv @@
// region_growing_segmenter: top level, joins the controller and the datapath
// depends on rgs_pkg, rgs_ctrl and rgs_dp
`default_nettype none

// Grey image region grower. Load requests can follow back to back while the result
// port accepts and no configuration write is pending; a query makes five label reads
// through the single label memory read port. A seed tries each neighbour in turn: a
// read, a label test when in bounds, a join step when unlabelled that takes it if it
// is near enough to the mean, then a step on; each finished frame is unwound from the stack.
// After reset the label memory is cleared before the first request is taken; each
// configuration write starts the load position divider before requests are taken again.
module region_growing_segmenter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  rgs_pkg::in_t       in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rgs_pkg::out_t      out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [8:0]    cfg_data_i
);
  import rgs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  rgs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
